// File: hdl/ssba_pkg.sv
// Shared types and field widths for the swap slot bitmap allocator.
`default_nettype none

package ssba_pkg;

  localparam int OP_W         = 2;
  localparam int SLOT_FIELD_W = 10;
  localparam int SECTOR_W     = 13;
  localparam int STATUS_W     = 2;
  localparam int CFG_W        = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_SWAP_IN  = 2'd1,
    OP_RELEASE  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2
  } status_t;

  typedef struct packed {
    op_t                     op;
    logic [SLOT_FIELD_W-1:0] slot;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/ssba_if.sv
// Request and result channel interfaces of the swap slot bitmap allocator.
`default_nettype none

interface ssba_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [ssba_pkg::OP_W-1:0]             op;
  logic [ssba_pkg::SLOT_FIELD_W-1:0]     slot;

  modport source (output valid, output op, output slot, input ready);
  modport sink   (input valid, input op, input slot, output ready);
endinterface

interface ssba_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [ssba_pkg::SLOT_FIELD_W-1:0]     slot_index;
  logic [ssba_pkg::SECTOR_W-1:0]         sector;
  logic [ssba_pkg::STATUS_W-1:0]         status;
  logic                                  last;

  modport source (output valid, output slot_index, output sector, output status,
                  output last, input ready);
  modport sink   (input valid, input slot_index, input sector, input status,
                  input last, output ready);
endinterface

`default_nettype wire

// File: hdl/swap_slot_bitmap_allocator.sv
// Swap slot bitmap allocator: first-fit slot allocation with sector address output.
// Timing: an allocate reads and checks one bitmap row at a time until it finds a slot; the
//   result beats then follow one per cycle while rsp.ready is high.
// Throughput: one item at a time; the engine takes a new command only after the last beat of
//   the current result is loaded.
// Reset: synchronous; slots_available goes to 1024, then a pass over every row clears the
//   bitmap RAM while requests are held off.
`default_nettype none

module swap_slot_bitmap_allocator #(
  parameter int MAX_SLOTS        = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [ssba_pkg::CFG_W-1:0]  cfg_wdata,
  ssba_req_if.sink                         req,
  ssba_rsp_if.source                       rsp
);

  import ssba_pkg::*;

  // Active slot count register; the engine clamps it to MAX_SLOTS.
  logic [CFG_W-1:0] slots_available;

  // Front end to queue
  logic             push;
  cmd_t             push_cmd;

  // Queue to slot engine
  cmd_t             head;
  logic             q_full;
  logic             q_empty;
  logic             pop;

  // High while the engine sweeps the bitmap after reset
  logic             init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_available <= CFG_RESET;
    end else if (cfg_we) begin
      slots_available <= cfg_wdata;
    end
  end

  // Accept beats and classify them; unknown ops are dropped here.
  ssba_front u_front (
    .req       (req),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Short queue lets the request side keep moving while results stall.
  ssba_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Bitmap RAM, first-fit search, slot check/free and the result beats.
  ssba_back #(
    .MAX_SLOTS        (MAX_SLOTS),
    .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .slots_available (slots_available),
    .head            (head),
    .q_empty         (q_empty),
    .pop             (pop),
    .init_busy       (init_busy),
    .rsp             (rsp)
  );

endmodule

`default_nettype wire

// File: hdl/ssba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/ssba_front.sv
// Front end: accepts request beats, drops unknown ops, pushes commands.
`default_nettype none

module ssba_front (
  ssba_req_if.sink              req,
  input  wire logic             init_busy,
  input  wire logic             q_full,
  output      logic             push,
  output      ssba_pkg::cmd_t   push_cmd
);

  import ssba_pkg::*;

  logic op_known;

  assign req.ready = !init_busy && !q_full;

  always_comb begin
    unique case (req.op)
      OP_ALLOC, OP_SWAP_IN, OP_RELEASE: op_known = 1'b1;
      default:                          op_known = 1'b0;
    endcase
  end

  // An unknown op is taken off the channel and produces nothing.
  assign push          = req.valid && req.ready && op_known;
  assign push_cmd.op   = op_t'(req.op);
  assign push_cmd.slot = req.slot;

endmodule

`default_nettype wire

// File: hdl/ssba_cmd_queue.sv
// Two-entry command queue between the front end and the slot engine.
`default_nettype none

module ssba_cmd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ssba_pkg::cmd_t   push_cmd,
  input  wire logic             pop,
  output      ssba_pkg::cmd_t   head,
  output      logic             full,
  output      logic             empty
);

  import ssba_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = entry[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= push_cmd;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/ssba_back.sv
// Slot engine: bitmap RAM, first-fit row scan, free/check, result sequencing.
`default_nettype none

module ssba_back #(
  parameter int MAX_SLOTS        = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ssba_pkg::CFG_W-1:0]    slots_available,
  input  wire ssba_pkg::cmd_t                head,
  input  wire logic                          q_empty,
  output      logic                          pop,
  output      logic                          init_busy,
  ssba_rsp_if.source                         rsp
);

  import ssba_pkg::*;

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int ROW_W  = (MAX_SLOTS < 32) ? 2 ** SLOT_W : 32;
  localparam int BIT_W  = $clog2(ROW_W);
  localparam int ROWS   = (MAX_SLOTS + ROW_W - 1) / ROW_W;
  localparam int RA_W   = (SLOT_W > BIT_W) ? SLOT_W - BIT_W : 1;
  localparam int IW     = ((SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W) + 1;
  localparam int LIM_W  = (SLOT_W + 1 > CFG_W) ? SLOT_W + 1 : CFG_W;
  localparam int OFF_W  = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
  localparam int SPS_W  = $clog2(SECTORS_PER_SLOT + 1);
  localparam int PROD_W = (SLOT_W + SPS_W > SECTOR_W) ? SLOT_W + SPS_W : SECTOR_W;

  localparam logic [LIM_W-1:0] MAX_LIM  = LIM_W'(MAX_SLOTS);
  localparam logic [RA_W-1:0]  LAST_ROW = RA_W'(ROWS - 1);
  localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(SECTORS_PER_SLOT - 1);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_ALLOC_RD = 7'b0000100,
    S_ALLOC_EV = 7'b0001000,
    S_CHECK_RD = 7'b0010000,
    S_CHECK_EV = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t                  state;
  logic [RA_W-1:0]         clear_row;
  logic [RA_W:0]           scan_row;
  logic [RA_W:0]           hint;
  op_t                     cmd_op;
  logic [SLOT_FIELD_W-1:0] cmd_slot;

  logic [SLOT_W-1:0]       res_slot;
  logic [SLOT_FIELD_W-1:0] res_index;
  status_t                 res_status;
  logic                    res_multi;
  logic [OFF_W-1:0]        cnt;

  logic                    out_valid;
  logic [SLOT_FIELD_W-1:0] out_slot_index;
  logic [SECTOR_W-1:0]     out_sector;
  status_t                 out_status;
  logic                    out_last;

  // RAM ports
  logic                    ram_we;
  logic [RA_W-1:0]         ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  logic [RA_W-1:0]         ram_raddr;
  logic [ROW_W-1:0]        ram_rdata;

  // Decode of the command slot
  logic [IW-1:0]           slot_wide;
  logic                    in_range;
  logic [SLOT_W-1:0]       slot_idx;
  logic [RA_W-1:0]         slot_row;
  logic [BIT_W-1:0]        slot_bit;
  logic [ROW_W-1:0]        slot_mask;
  logic                    slot_used;

  // Allocation search
  logic [LIM_W-1:0]        cfg_ext;
  logic [LIM_W-1:0]        lim;
  logic [LIM_W-1:0]        row_base;
  logic                    free_found;
  logic [BIT_W-1:0]        free_bit;
  logic [LIM_W-1:0]        found_idx;
  logic                    alloc_ok;
  logic [ROW_W-1:0]        free_mask;

  // Result sequencing
  logic                    out_load;
  logic                    emit_last;
  logic [PROD_W-1:0]       sector_full;

  ssba_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_wide = IW'(cmd_slot);
  assign in_range  = slot_wide < IW'(MAX_SLOTS);
  assign slot_idx  = slot_wide[SLOT_W-1:0];
  assign slot_row  = RA_W'(slot_idx >> BIT_W);
  assign slot_bit  = slot_idx[BIT_W-1:0];
  assign slot_mask = ROW_W'(1) << slot_bit;
  assign slot_used = ram_rdata[slot_bit];

  assign cfg_ext  = LIM_W'(slots_available);
  assign lim      = (cfg_ext > MAX_LIM) ? MAX_LIM : cfg_ext;
  assign row_base = LIM_W'(scan_row) << BIT_W;

  // Lowest clear bit of the row just read
  always_comb begin
    free_found = 1'b0;
    free_bit   = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        free_found = 1'b1;
        free_bit   = BIT_W'(i);
      end
    end
  end

  assign found_idx = row_base | LIM_W'(free_bit);
  assign alloc_ok  = free_found && (found_idx < lim);
  assign free_mask = ROW_W'(1) << free_bit;

  assign ram_raddr = (state == S_ALLOC_RD) ? scan_row[RA_W-1:0] : slot_row;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_row;
    ram_wdata = ram_rdata & ~slot_mask;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_row;
        ram_wdata = '0;
      end
      S_ALLOC_EV: begin
        ram_we    = alloc_ok;
        ram_waddr = scan_row[RA_W-1:0];
        ram_wdata = ram_rdata | free_mask;
      end
      S_CHECK_EV: begin
        ram_we    = slot_used;
      end
      default: begin
        ram_we    = 1'b0;
      end
    endcase
  end

  assign pop       = (state == S_IDLE) && !q_empty;
  assign init_busy = (state == S_CLEAR);

  assign out_load    = (state == S_EMIT) && (!out_valid || rsp.ready);
  assign emit_last   = !res_multi || (cnt == LAST_OFF);
  assign sector_full = PROD_W'(res_slot) * PROD_W'(SECTORS_PER_SLOT) + PROD_W'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clear_row <= '0;
      hint      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid      <= 1'b1;
        out_slot_index <= res_index;
        out_status     <= res_status;
        out_last       <= emit_last;
        out_sector     <= res_multi ? sector_full[SECTOR_W-1:0] : '0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clear_row <= clear_row + RA_W'(1);
          if (clear_row == LAST_ROW) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd_op   <= head.op;
            cmd_slot <= head.slot;
            scan_row <= hint;
            state    <= (head.op == OP_ALLOC) ? S_ALLOC_RD : S_CHECK_RD;
          end
        end
        S_ALLOC_RD: begin
          // Rows below the hint are full; past the limit the table is full.
          if (row_base >= lim) begin
            res_index  <= '0;
            res_status <= ST_FULL;
            res_multi  <= 1'b0;
            state      <= S_EMIT;
          end else begin
            state <= S_ALLOC_EV;
          end
        end
        S_ALLOC_EV: begin
          if (alloc_ok) begin
            hint       <= scan_row;
            res_slot   <= found_idx[SLOT_W-1:0];
            res_index  <= found_idx[SLOT_FIELD_W-1:0];
            res_status <= ST_OK;
            res_multi  <= 1'b1;
            cnt        <= '0;
            state      <= S_EMIT;
          end else if (free_found) begin
            res_index  <= '0;
            res_status <= ST_FULL;
            res_multi  <= 1'b0;
            state      <= S_EMIT;
          end else begin
            scan_row <= scan_row + (RA_W + 1)'(1);
            hint     <= scan_row + (RA_W + 1)'(1);
            state    <= S_ALLOC_RD;
          end
        end
        S_CHECK_RD: begin
          if (!in_range) begin
            res_index  <= cmd_slot;
            res_status <= ST_NOT_USED;
            res_multi  <= 1'b0;
            state      <= S_EMIT;
          end else begin
            state <= S_CHECK_EV;
          end
        end
        S_CHECK_EV: begin
          res_index <= cmd_slot;
          res_slot  <= slot_idx;
          cnt       <= '0;
          if (!slot_used) begin
            res_status <= ST_NOT_USED;
            res_multi  <= 1'b0;
          end else begin
            res_status <= ST_OK;
            res_multi  <= (cmd_op == OP_SWAP_IN);
            if ({1'b0, slot_row} < hint) begin
              hint <= {1'b0, slot_row};
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            cnt <= cnt + OFF_W'(1);
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.slot_index = out_slot_index;
  assign rsp.sector     = out_sector;
  assign rsp.status     = out_status;
  assign rsp.last       = out_last;

endmodule

`default_nettype wire

// File: tb/ssba_slot_checker.sv
// Checker for the swap slot allocator: predicts result beats and compares them.
`timescale 1ns / 1ps

module ssba_slot_checker #(
  parameter int MAX_SLOTS        = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ssba_pkg::CFG_W-1:0] cfg_wdata,
  ssba_req_if                        req,
  ssba_rsp_if                        rsp,
  output int                         mismatches,
  output int                         beats_owed,
  output int                         cmds_seen,
  output int                         beats_seen,
  output int                         full_seen,
  output int                         unused_seen
);

  import ssba_pkg::*;

  typedef struct {
    logic [SLOT_FIELD_W-1:0] slot_index;
    logic [SECTOR_W-1:0]     sector;
    status_t                 status;
    logic                    last;
  } slot_beat_t;

  slot_beat_t       owed_beats[$];
  bit               slot_taken[MAX_SLOTS];
  logic [CFG_W-1:0] slot_count;
  int               err_count;
  int               cmd_count;
  int               beat_count;
  int               full_count;
  int               unused_count;

  function automatic void owe(logic [SLOT_FIELD_W-1:0] idx, logic [SECTOR_W-1:0] sec,
                              status_t st, logic lst);
    slot_beat_t b;
    b.slot_index = idx;
    b.sector     = sec;
    b.status     = st;
    b.last       = lst;
    owed_beats.push_back(b);
  endfunction

  function automatic void owe_sectors(logic [SLOT_FIELD_W-1:0] idx);
    for (int k = 0; k < SECTORS_PER_SLOT; k++)
      owe(idx, SECTOR_W'(idx * SECTORS_PER_SLOT + k), ST_OK, k == SECTORS_PER_SLOT - 1);
  endfunction

  function automatic void predict_cmd(logic [OP_W-1:0] op, logic [SLOT_FIELD_W-1:0] slot);
    int active;
    int pick;
    active = (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
    pick   = -1;
    case (op)
      OP_ALLOC: begin
        for (int i = 0; i < active; i++) begin
          if (!slot_taken[i]) begin
            pick = i;
            break;
          end
        end
        if (pick < 0) begin
          owe('0, '0, ST_FULL, 1'b1);
          full_count++;
        end else begin
          slot_taken[pick] = 1'b1;
          owe_sectors(SLOT_FIELD_W'(pick));
        end
      end
      OP_SWAP_IN, OP_RELEASE: begin
        if (slot >= MAX_SLOTS || !slot_taken[slot]) begin
          owe(slot, '0, ST_NOT_USED, 1'b1);
          unused_count++;
        end else begin
          if (op == OP_SWAP_IN) owe_sectors(slot);
          else owe(slot, '0, ST_OK, 1'b1);
          slot_taken[slot] = 1'b0;
        end
      end
      default: ;  // unknown op: no beat, no change
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    slot_beat_t want;
    if (rst) begin
      owed_beats.delete();
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      slot_count   = CFG_RESET;
      err_count    = 0;
      cmd_count    = 0;
      beat_count   = 0;
      full_count   = 0;
      unused_count = 0;
    end else begin
      // retire the result beat first; a command accepted on this edge cannot have produced it
      if (rsp.valid && rsp.ready) begin
        beat_count++;
        if (owed_beats.size() == 0) begin
          err_count++;
          $display("%0t: beat expected none, got slot %0d sector %0d status %0d last %0d",
                   $time, rsp.slot_index, rsp.sector, rsp.status, rsp.last);
        end else begin
          want = owed_beats.pop_front();
          check_field("slot_index", want.slot_index, rsp.slot_index);
          check_field("sector", want.sector, rsp.sector);
          check_field("status", int'(want.status), rsp.status);
          check_field("last", want.last, rsp.last);
        end
      end
      if (req.valid && req.ready) begin
        cmd_count++;
        predict_cmd(req.op, req.slot);
      end
      if (cfg_we) slot_count = cfg_wdata;
    end
    mismatches  <= err_count;
    beats_owed  <= owed_beats.size();
    cmds_seen   <= cmd_count;
    beats_seen  <= beat_count;
    full_seen   <= full_count;
    unused_seen <= unused_count;
  end

endmodule

// File: tb/swap_slot_bitmap_allocator_tb.sv
// Top of the swap slot allocator testbench: clock, reset, commands, result pacing, verdict.
`timescale 1ns / 1ps

module swap_slot_bitmap_allocator_tb;
  import ssba_pkg::*;

  // op code the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // cycles with no beat on either channel before the run is declared hung
  localparam int HANG_LIMIT = 4000;
  // quiet time after the last owed beat: covers an ignored command and a full bitmap scan
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_CMDS = 41;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  int mismatches;
  int beats_owed;
  int cmds_seen;
  int beats_seen;
  int full_seen;
  int unused_seen;
  int idle_cycles = 0;
  int cur_count   = 1024;
  int settings    = 0;
  bit calm        = 1'b0;

  // slot counts for the random phases; zero and the 11-bit maximum are hit in the directed part
  int phase_counts[7] = '{5, 2047, 17, 1, 40, 1024, 9};

  ssba_req_if req ();
  ssba_rsp_if rsp ();

  swap_slot_bitmap_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  ssba_slot_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req         (req),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .beats_owed  (beats_owed),
    .cmds_seen   (cmds_seen),
    .beats_seen  (beats_seen),
    .full_seen   (full_seen),
    .unused_seen (unused_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: reset any time a beat moves on either channel, give up after a long silence.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("no beat for %0d cycles at %0t", HANG_LIMIT, $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: hold ready high for random stretches, drop it for random bursts in between
  // unless the run is in its calm tail.
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Send one command beat. Optionally idle first; then hold valid until the block takes it.
  // Valid stays high on return so back-to-back beats go without a gap.
  task automatic push_cmd(logic [OP_W-1:0] op, logic [SLOT_FIELD_W-1:0] slot);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.slot  <= slot;
    do @(posedge clk); while (!req.ready);
  endtask

  // Drop valid, wait until every owed beat has left, then let the block go quiet.
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (beats_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the slot count only with the block idle.
  task automatic set_slot_count(int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_count = value;
    settings++;
  endtask

  // Aim swap-in and release mostly at low slots, where allocations land, so that
  // most of them hit a used slot; one in five goes anywhere in the 10-bit field.
  function automatic logic [SLOT_FIELD_W-1:0] pick_slot();
    int span;
    span = (cur_count < 24) ? cur_count : 24;
    if ($urandom_range(0, 4) == 0) return SLOT_FIELD_W'($urandom);
    return SLOT_FIELD_W'($urandom_range(0, span + 1));
  endfunction

  task automatic random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      push_cmd(OP_ALLOC, SLOT_FIELD_W'($urandom));
    else if (r < 70) push_cmd(OP_SWAP_IN, pick_slot());
    else if (r < 94) push_cmd(OP_RELEASE, pick_slot());
    else             push_cmd(OP_UNUSED, SLOT_FIELD_W'($urandom));
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    req.valid <= 1'b0;
    req.op    <= OP_ALLOC;
    req.slot  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The drain inside the first write also covers the bitmap clearing pass.
    set_slot_count(1024);
    push_cmd(OP_RELEASE, '0);          // release of a free slot
    push_cmd(OP_SWAP_IN, '1);          // swap-in of a free slot, top index
    push_cmd(OP_UNUSED, '1);           // ignored op
    push_cmd(OP_ALLOC, '1);            // slot field ignored: takes 0
    push_cmd(OP_ALLOC, '0);            // takes 1
    push_cmd(OP_ALLOC, 10'h155);       // takes 2
    push_cmd(OP_SWAP_IN, 10'd1);       // sectors of 1, then free it
    push_cmd(OP_ALLOC, 10'h2AA);       // first fit reuses 1
    push_cmd(OP_RELEASE, 10'd2);       // good release
    push_cmd(OP_RELEASE, 10'd2);       // now free again
    push_cmd(OP_SWAP_IN, 10'd0);       // slot 0 back to free

    // Zero slot count: allocate reports full, but slot 1 stays usable.
    set_slot_count(0);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_RELEASE, 10'd1);
    push_cmd(OP_ALLOC, '1);

    // One slot: fill it, hit full, free it.
    set_slot_count(1);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_SWAP_IN, 10'd0);

    // Above the slot array size: acts as the full array.
    set_slot_count(2047);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_ALLOC, '0);
    push_cmd(OP_RELEASE, 10'h2AA);
    push_cmd(OP_SWAP_IN, 10'h155);

    // Random phases, one slot count each. Small counts keep the table filling and
    // emptying; a count lowered under live slots leaves them to be swapped in or released.
    // The last phase runs with no idling on either side.
    for (int p = 0; p < 7; p++) begin
      set_slot_count(phase_counts[p]);
      calm = (p == 6);
      repeat (PHASE_CMDS) random_cmd();
    end

    drain();
    $display("Covered %0d commands and %0d result beats over %0d slot-count settings,",
             cmds_seen, beats_seen, settings);
    $display("with %0d table-full and %0d slot-not-in-use results.", full_seen, unused_seen);
    if (mismatches == 0 && beats_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
